[rtl/sdst_pkg.sv]
// Shared types, codes and constants of the sparse disk sector translator.
package sdst_pkg;

    localparam int DEF_MAX_BLOCKS        = 256;
    localparam int DEF_MAX_BLOCK_SECTORS = 4096;
    localparam int DEF_MAX_REQUEST       = 64;

    localparam int PAD_SECTORS = 5;
    localparam int TBL_W       = 33;
    localparam int CUR_W       = 29;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_DISK_SIZE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE_LOG2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BITMAP_SECTORS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_ONLY       = 3'd4;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ST_PRESENT = 2'd0,
        ST_ZERO    = 2'd1,
        ST_RANGE   = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    typedef struct packed {
        logic [27:0] disk_size;
        logic [4:0]  block_size_log2;
        logic [4:0]  bitmap_sectors;
        logic        read_only;
    } cfg_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] phys_sector;
        logic        block_created;
        logic [15:0] block_index;
        logic [31:0] block_start;
        logic        last;
    } result_t;

endpackage

[rtl/sdst_ram.sv]
// Generic simple dual-port RAM with registered read.
module sdst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/sdst_ctrl.sv]
// Sector sequencer: address split, table lookup, allocation and present-bit update.
module sdst_ctrl #(
    parameter int MAX_BLOCKS        = sdst_pkg::DEF_MAX_BLOCKS,
    parameter int MAX_BLOCK_SECTORS = sdst_pkg::DEF_MAX_BLOCK_SECTORS,
    parameter int MAX_REQUEST       = sdst_pkg::DEF_MAX_REQUEST,
    localparam int BLK_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
    localparam int LGMAX   = $clog2(MAX_BLOCK_SECTORS),
    localparam int PW      = (MAX_BLOCK_SECTORS >= 32) ? 32 : MAX_BLOCK_SECTORS,
    localparam int WPB     = MAX_BLOCK_SECTORS / PW,
    localparam int PA_W    = $clog2(MAX_BLOCKS * WPB)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sdst_pkg::cfg_t              cfg,
    input  logic                        nf_load,
    input  logic [31:0]                 nf_value,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_func,
    input  logic [27:0]                 in_start,
    input  logic [6:0]                  in_count,
    output logic                        out_valid,
    input  logic                        out_ready,
    output sdst_pkg::result_t           out_res,
    output logic                        tbl_we,
    output logic [BLK_W-1:0]            tbl_waddr,
    output logic [sdst_pkg::TBL_W-1:0]  tbl_wdata,
    output logic [BLK_W-1:0]            tbl_raddr,
    input  logic [sdst_pkg::TBL_W-1:0]  tbl_rdata,
    output logic                        pb_we,
    output logic [PA_W-1:0]             pb_waddr,
    output logic [PW-1:0]               pb_wdata,
    output logic [PA_W-1:0]             pb_raddr,
    input  logic [PW-1:0]               pb_rdata
);

    localparam int WL      = $clog2(PW);
    localparam int WPB_LOG = $clog2(WPB);
    localparam int CC_W    = WPB_LOG + 1;
    localparam int REQ_W   = $clog2(MAX_REQUEST + 1);
    localparam int CUR_W   = sdst_pkg::CUR_W;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_ADDR  = 9'b000000100,
        S_LOOK  = 9'b000001000,
        S_TBL   = 9'b000010000,
        S_ZERO  = 9'b000100000,
        S_PREAD = 9'b001000000,
        S_BIT   = 9'b010000000,
        S_EMIT  = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    logic [BLK_W-1:0]    init_reg, init_next;
    logic [CC_W-1:0]     clr_reg, clr_next;
    logic                func_reg, func_next;
    logic [CUR_W-1:0]    cursor_reg, cursor_next;
    logic [REQ_W-1:0]    remaining_reg, remaining_next;
    logic [31:0]         nf_reg, nf_next;
    logic [BLK_W-1:0]    blk_reg, blk_next;
    logic [LGMAX-1:0]    sib_reg, sib_next;
    sdst_pkg::status_t   status_reg, status_next;
    logic [31:0]         bstart_reg, bstart_next;
    logic                created_reg, created_next;
    logic                has_blk_reg, has_blk_next;
    logic                bidx_ok_reg, bidx_ok_next;
    logic                out_valid_reg, out_valid_next;
    sdst_pkg::result_t   out_res_reg, out_res_next;

    logic [4:0]          lg_eff;
    logic [CUR_W-1:0]    s_shift;
    logic [LGMAX-1:0]    sib_mask;
    logic                oor;
    logic                ro_write;
    logic [REQ_W-1:0]    cnt_sat;
    logic [PA_W-1:0]     pa_base;
    logic [PA_W-1:0]     pa_sector;
    logic [PW-1:0]       bit_mask;
    logic                tbl_valid;
    logic [31:0]         tbl_start;
    logic                emit_ok;
    logic [31:0]         phys;
    logic [31:0]         nf_step;

    assign lg_eff    = (cfg.block_size_log2 > 5'(LGMAX)) ? 5'(LGMAX) : cfg.block_size_log2;
    assign s_shift   = cursor_reg >> lg_eff;
    assign sib_mask  = LGMAX'((32'd1 << lg_eff) - 32'd1);
    assign oor       = (cursor_reg >= CUR_W'(cfg.disk_size))
                    || (s_shift >= CUR_W'(MAX_BLOCKS));
    assign ro_write  = (func_reg == sdst_pkg::FUNC_WRITE) && cfg.read_only;
    assign cnt_sat   = (in_count > 7'(MAX_REQUEST)) ? REQ_W'(MAX_REQUEST) : REQ_W'(in_count);
    assign pa_base   = PA_W'(blk_reg) << WPB_LOG;
    assign pa_sector = pa_base | PA_W'(sib_reg >> WL);
    assign bit_mask  = PW'(1) << sib_reg[WL-1:0];
    assign tbl_valid = tbl_rdata[sdst_pkg::TBL_W-1];
    assign tbl_start = tbl_rdata[31:0];
    assign emit_ok   = !out_valid_reg || out_ready;
    assign phys      = has_blk_reg ? (bstart_reg + 32'(cfg.bitmap_sectors) + 32'(sib_reg))
                                   : 32'd0;
    assign nf_step   = 32'(cfg.bitmap_sectors) + (32'd1 << lg_eff) + 32'(sdst_pkg::PAD_SECTORS);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    assign tbl_raddr = blk_reg;
    assign pb_raddr  = pa_sector;

    always_comb
    begin
        state_next     = state_reg;
        init_next      = init_reg;
        clr_next       = clr_reg;
        func_next      = func_reg;
        cursor_next    = cursor_reg;
        remaining_next = remaining_reg;
        nf_next        = nf_reg;
        blk_next       = blk_reg;
        sib_next       = sib_reg;
        status_next    = status_reg;
        bstart_next    = bstart_reg;
        created_next   = created_reg;
        has_blk_next   = has_blk_reg;
        bidx_ok_next   = bidx_ok_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_res_next   = out_res_reg;
        tbl_we         = 1'b0;
        tbl_waddr      = blk_reg;
        tbl_wdata      = {1'b1, nf_reg};
        pb_we          = 1'b0;
        pb_waddr       = pa_sector;
        pb_wdata       = pb_rdata | bit_mask;

        unique case (state_reg)
            S_CLEAR:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = init_reg;
                tbl_wdata = '0;
                init_next = init_reg + BLK_W'(1);
                if (init_reg == BLK_W'(MAX_BLOCKS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next      = in_func;
                    cursor_next    = CUR_W'(in_start);
                    remaining_next = cnt_sat;
                    if (cnt_sat != '0)
                    begin
                        state_next = S_ADDR;
                    end
                end
            end
            S_ADDR:
            begin
                blk_next     = s_shift[BLK_W-1:0];
                sib_next     = cursor_reg[LGMAX-1:0] & sib_mask;
                bstart_next  = '0;
                created_next = 1'b0;
                has_blk_next = 1'b0;
                bidx_ok_next = 1'b0;
                priority if (ro_write)
                begin
                    status_next = sdst_pkg::ST_IGNORED;
                    state_next  = S_EMIT;
                end
                else if (oor)
                begin
                    status_next = sdst_pkg::ST_RANGE;
                    state_next  = S_EMIT;
                end
                else
                begin
                    bidx_ok_next = 1'b1;
                    state_next   = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_TBL;
            end
            S_TBL:
            begin
                priority if (!tbl_valid && func_reg == sdst_pkg::FUNC_READ)
                begin
                    status_next = sdst_pkg::ST_ZERO;
                    state_next  = S_EMIT;
                end
                else if (!tbl_valid)
                begin
                    tbl_we       = 1'b1;
                    bstart_next  = nf_reg;
                    nf_next      = nf_reg + nf_step;
                    created_next = 1'b1;
                    has_blk_next = 1'b1;
                    clr_next     = '0;
                    state_next   = S_ZERO;
                end
                else
                begin
                    bstart_next  = tbl_start;
                    has_blk_next = 1'b1;
                    state_next   = S_PREAD;
                end
            end
            S_ZERO:
            begin
                pb_we    = 1'b1;
                pb_waddr = pa_base | PA_W'(clr_reg);
                pb_wdata = '0;
                clr_next = clr_reg + CC_W'(1);
                if (clr_reg == CC_W'(WPB - 1))
                begin
                    state_next = S_PREAD;
                end
            end
            S_PREAD:
            begin
                state_next = S_BIT;
            end
            S_BIT:
            begin
                if (func_reg == sdst_pkg::FUNC_WRITE)
                begin
                    pb_we       = 1'b1;
                    status_next = sdst_pkg::ST_PRESENT;
                end
                else
                begin
                    status_next = pb_rdata[sib_reg[WL-1:0]] ? sdst_pkg::ST_PRESENT
                                                            : sdst_pkg::ST_ZERO;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (emit_ok)
                begin
                    out_valid_next             = 1'b1;
                    out_res_next.status        = status_reg;
                    out_res_next.phys_sector   = phys;
                    out_res_next.block_created = created_reg;
                    out_res_next.block_index   = bidx_ok_reg ? 16'(blk_reg) : 16'd0;
                    out_res_next.block_start   = bstart_reg;
                    out_res_next.last          = (remaining_reg == REQ_W'(1));
                    cursor_next                = cursor_reg + CUR_W'(1);
                    remaining_next             = remaining_reg - REQ_W'(1);
                    state_next = (remaining_reg == REQ_W'(1)) ? S_IDLE : S_ADDR;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        if (nf_load)
        begin
            nf_next = nf_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            init_reg      <= '0;
            clr_reg       <= '0;
            remaining_reg <= '0;
            cursor_reg    <= '0;
            nf_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            clr_reg       <= clr_next;
            remaining_reg <= remaining_next;
            cursor_reg    <= cursor_next;
            nf_reg        <= nf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        blk_reg     <= blk_next;
        sib_reg     <= sib_next;
        status_reg  <= status_next;
        bstart_reg  <= bstart_next;
        created_reg <= created_next;
        has_blk_reg <= has_blk_next;
        bidx_ok_reg <= bidx_ok_next;
        out_res_reg <= out_res_next;
    end

endmodule

[rtl/sparse_disk_sector_translation.sv]
// Each sector passes address split, table lookup and a present-bit read or update; a read
// of a sparse block skips the present bits, and an ignored or out-of-range sector goes
// straight to its result. A write that allocates a block first clears its present-bit
// words. A new request is accepted only once the previous one has issued its last result.
// Reset: a clearing pass over all MAX_BLOCKS (256 by default) table entries marks every
// block sparse; no request is accepted until it ends, configuration writes are taken throughout.
module sparse_disk_sector_translation #(
    parameter int MAX_BLOCKS        = sdst_pkg::DEF_MAX_BLOCKS,
    parameter int MAX_BLOCK_SECTORS = sdst_pkg::DEF_MAX_BLOCK_SECTORS,
    parameter int MAX_REQUEST       = sdst_pkg::DEF_MAX_REQUEST
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [39:0]                    s_tdata,   // start_sector, num_sectors
    input  logic [0:0]                     s_tuser,   // func
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [79:0]                    m_tdata,   // phys_sector, block_index, block_start
    output logic [2:0]                     m_tuser,   // status, block_created
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sdst_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);

    localparam int BLK_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int PW    = (MAX_BLOCK_SECTORS >= 32) ? 32 : MAX_BLOCK_SECTORS;
    localparam int WPB   = MAX_BLOCK_SECTORS / PW;
    localparam int PA_W  = $clog2(MAX_BLOCKS * WPB);

    sdst_pkg::cfg_t    cfg_reg, cfg_next;
    sdst_pkg::result_t res;
    logic              cfg_wr;
    logic              nf_load;

    logic                        tbl_we;
    logic [BLK_W-1:0]            tbl_waddr;
    logic [sdst_pkg::TBL_W-1:0]  tbl_wdata;
    logic [BLK_W-1:0]            tbl_raddr;
    logic [sdst_pkg::TBL_W-1:0]  tbl_rdata;
    logic                        pb_we;
    logic [PA_W-1:0]             pb_waddr;
    logic [PW-1:0]               pb_wdata;
    logic [PA_W-1:0]             pb_raddr;
    logic [PW-1:0]               pb_rdata;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign nf_load   = cfg_wr && (cfg_index == sdst_pkg::CFG_FIRST_FREE);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (cfg_index)
                sdst_pkg::CFG_DISK_SIZE:       cfg_next.disk_size       = cfg_data[27:0];
                sdst_pkg::CFG_BLOCK_SIZE_LOG2: cfg_next.block_size_log2 = cfg_data[4:0];
                sdst_pkg::CFG_BITMAP_SECTORS:  cfg_next.bitmap_sectors  = cfg_data[4:0];
                sdst_pkg::CFG_READ_ONLY:       cfg_next.read_only       = cfg_data[0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.disk_size       <= '0;
            cfg_reg.block_size_log2 <= 5'd12;
            cfg_reg.bitmap_sectors  <= 5'd1;
            cfg_reg.read_only       <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sdst_ctrl #(
        .MAX_BLOCKS        (MAX_BLOCKS),
        .MAX_BLOCK_SECTORS (MAX_BLOCK_SECTORS),
        .MAX_REQUEST       (MAX_REQUEST)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .nf_load   (nf_load),
        .nf_value  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (s_tuser[0]),
        .in_start  (s_tdata[27:0]),
        .in_count  (s_tdata[34:28]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res),
        .tbl_we    (tbl_we),
        .tbl_waddr (tbl_waddr),
        .tbl_wdata (tbl_wdata),
        .tbl_raddr (tbl_raddr),
        .tbl_rdata (tbl_rdata),
        .pb_we     (pb_we),
        .pb_waddr  (pb_waddr),
        .pb_wdata  (pb_wdata),
        .pb_raddr  (pb_raddr),
        .pb_rdata  (pb_rdata)
    );

    sdst_ram #(
        .WIDTH (sdst_pkg::TBL_W),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    sdst_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_BLOCKS * WPB)
    ) u_present (
        .clk   (clk),
        .we    (pb_we),
        .waddr (pb_waddr),
        .wdata (pb_wdata),
        .raddr (pb_raddr),
        .rdata (pb_rdata)
    );

    assign m_tdata = {res.block_start, res.block_index, res.phys_sector};
    assign m_tuser = {res.block_created, res.status};
    assign m_tlast = res.last;

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the sparse disk sector translator with its own block model.
module tb;
    import sdst_pkg::*;

    localparam int NBLK   = DEF_MAX_BLOCKS;
    localparam int NSEC   = DEF_MAX_BLOCK_SECTORS;
    localparam int NREQ   = DEF_MAX_REQUEST;
    localparam int LG_MAX = $clog2(DEF_MAX_BLOCK_SECTORS);
    localparam logic [27:0] LAST_SECTOR = 28'd267386879;
    localparam logic [27:0] DISK_MAX    = 28'd267386880;
    localparam logic [27:0] ALL_ONES    = 28'hFFFFFFF;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [39:0]          s_tdata;   // start_sector, num_sectors
    logic [0:0]           s_tuser;   // func
    logic                 m_tvalid;
    logic                 m_tready;
    logic [79:0]          m_tdata;   // phys_sector, block_index, block_start
    logic [2:0]           m_tuser;   // status, block_created
    logic                 m_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    logic [27:0] disk_sectors = '0;
    logic [4:0]  blk_log2     = 5'd12;
    logic [4:0]  bmp_sectors  = 5'd1;
    logic [31:0] free_ptr     = '0;
    logic        wr_protect   = 1'b0;

    logic [31:0] block_base [NBLK];
    bit          block_mapped [NBLK];
    bit          sector_written [NBLK*NSEC];

    result_t     pending_results [$];
    logic [27:0] written_starts [$];
    int          error_count = 0;
    int          hold_cycles = 0;
    bit          quiet = 1'b0;

    sparse_disk_sector_translation DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic void translate_request(input logic func, input logic [27:0] start,
                                              input logic [6:0] count);
        int unsigned     n, lg, bsz, s, blk, sib, k;
        longint unsigned cap;
        result_t         r;
        n   = (count > NREQ) ? NREQ : count;
        lg  = (blk_log2 > LG_MAX) ? LG_MAX : blk_log2;
        bsz = 1 << lg;
        cap = longint'(NBLK) << lg;
        for (int i = 0; i < n; i++)
        begin
            s = start + i;
            r = '0;
            if (func == FUNC_WRITE && wr_protect)
                r.status = ST_IGNORED;
            else if (s >= disk_sectors || s >= cap)
                r.status = ST_RANGE;
            else
            begin
                blk = s >> lg;
                sib = s & (bsz - 1);
                k   = blk * NSEC + sib;
                r.block_index = blk[15:0];
                if (func == FUNC_WRITE)
                begin
                    if (!block_mapped[blk])
                    begin
                        block_base[blk]   = free_ptr;
                        block_mapped[blk] = 1'b1;
                        for (int j = 0; j < NSEC; j++)
                            sector_written[blk*NSEC+j] = 1'b0;
                        free_ptr = free_ptr + bmp_sectors + bsz + PAD_SECTORS;
                        r.block_created = 1'b1;
                    end
                    sector_written[k] = 1'b1;
                    r.status      = ST_PRESENT;
                    r.block_start = block_base[blk];
                    r.phys_sector = block_base[blk] + bmp_sectors + sib;
                end
                else if (!block_mapped[blk])
                    r.status = ST_ZERO;
                else
                begin
                    r.block_start = block_base[blk];
                    r.phys_sector = block_base[blk] + bmp_sectors + sib;
                    r.status      = sector_written[k] ? ST_PRESENT : ST_ZERO;
                end
            end
            r.last = (i + 1 == n);
            pending_results.push_back(r);
        end
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_DISK_SIZE:       disk_sectors = value[27:0];
            CFG_BLOCK_SIZE_LOG2: blk_log2     = value[4:0];
            CFG_BITMAP_SECTORS:  bmp_sectors  = value[4:0];
            CFG_FIRST_FREE:      free_ptr     = value;
            CFG_READ_ONLY:       wr_protect   = value[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_geometry(input logic [27:0] total, input logic [4:0] lg,
                                input logic [4:0] bmp, input logic [31:0] first,
                                input logic ro);
        write_register(CFG_DISK_SIZE, 32'(total));
        write_register(CFG_BLOCK_SIZE_LOG2, 32'(lg));
        write_register(CFG_BITMAP_SECTORS, 32'(bmp));
        write_register(CFG_FIRST_FREE, first);
        write_register(CFG_READ_ONLY, 32'(ro));
    endtask

    task automatic issue_request(input logic func, input logic [27:0] start,
                                 input logic [6:0] count);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, count, start};
        s_tuser  <= func;
        do @(posedge clk); while (!s_tready);
        translate_request(func, start, count);
        if (func == FUNC_WRITE)
        begin
            written_starts.push_back(start);
            if (written_starts.size() > 16)
                void'(written_starts.pop_front());
        end
    endtask

    task automatic issue_random_request;
        logic        func;
        logic [27:0] start;
        logic [6:0]  count;
        int unsigned lg, cap, pick;
        lg   = (blk_log2 > LG_MAX) ? LG_MAX : blk_log2;
        cap  = NBLK << lg;
        func = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 6)
            start = 28'($urandom_range(0, ALL_ONES));
        else if (func == FUNC_READ && pick < 60 && written_starts.size() > 0)
            start = written_starts[$urandom_range(0, written_starts.size() - 1)];
        else
            start = 28'($urandom_range(0, cap + 31));
        pick = $urandom_range(0, 99);
        if (pick < 3)
            count = 7'd0;
        else if (pick < 6)
            count = 7'($urandom_range(65, 127));
        else if (pick < 22)
            count = 7'($urandom_range(1, NREQ));
        else
            count = 7'($urandom_range(1, 8));
        issue_request(func, start, count);
    endtask

    task automatic settle;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic test_reset_state;
        issue_request(FUNC_READ, 28'd0, 7'd1);
        issue_request(FUNC_WRITE, 28'd5, 7'd2);
        settle();
    endtask

    task automatic test_translation;
        set_geometry(28'd5000, 5'd3, 5'd1, 32'd100, 1'b0);
        issue_request(FUNC_READ, 28'd10, 7'd1);
        issue_request(FUNC_WRITE, 28'd10, 7'd1);
        issue_request(FUNC_READ, 28'd8, 7'd4);
        issue_request(FUNC_WRITE, 28'd6, 7'd20);
        issue_request(FUNC_READ, 28'd0, 7'd64);
        issue_request(FUNC_WRITE, 28'd30, 7'd0);
        issue_request(FUNC_READ, 28'd4990, 7'd127);
        issue_request(FUNC_READ, ALL_ONES, 7'd3);
        issue_request(FUNC_WRITE, 28'd2046, 7'd4);
        issue_request(FUNC_READ, 28'd2046, 7'd4);
        settle();
    endtask

    task automatic test_read_only;
        write_register(CFG_READ_ONLY, 32'd1);
        issue_request(FUNC_WRITE, 28'd10, 7'd3);
        issue_request(FUNC_WRITE, ALL_ONES, 7'd2);
        issue_request(FUNC_READ, 28'd8, 7'd4);
        settle();
        write_register(CFG_READ_ONLY, 32'd0);
    endtask

    task automatic test_geometry_change;
        set_geometry(DISK_MAX, 5'd16, 5'd16, 32'hFFFFF000, 1'b0);
        issue_request(FUNC_READ, 28'd0, 7'd8);
        issue_request(FUNC_WRITE, 28'd5000, 7'd2);
        issue_request(FUNC_WRITE, 28'(200 * 4096 + 7), 7'd2);
        issue_request(FUNC_WRITE, 28'(201 * 4096), 7'd1);
        issue_request(FUNC_READ, 28'(255 * 4096 + 4094), 7'd3);
        issue_request(FUNC_READ, LAST_SECTOR, 7'd1);
        settle();
    endtask

    task automatic test_random_traffic;
        logic [27:0] total;
        logic [4:0]  lg;
        logic [31:0] first;
        int unsigned lg_eff;
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 0)
                set_geometry(DISK_MAX, 5'd3, 5'd16, 32'hFFFFFFFF, 1'b0);
            else if (phase == 1)
                set_geometry(28'd20000, 5'd16, 5'd1, 32'd0, 1'b0);
            else
            begin
                lg     = 5'($urandom_range(3, 16));
                lg_eff = (lg > LG_MAX) ? LG_MAX : lg;
                case ($urandom_range(0, 2))
                    0:       total = 28'($urandom_range(0, DISK_MAX));
                    1:       total = 28'($urandom_range(0, NBLK << lg_eff));
                    default: total = DISK_MAX;
                endcase
                case ($urandom_range(0, 2))
                    0:       first = 32'd0;
                    1:       first = 32'hFFFFFFFF - $urandom_range(0, 20000);
                    default: first = $urandom;
                endcase
                set_geometry(total, lg, 5'($urandom_range(1, 16)), first,
                             $urandom_range(0, 5) == 0);
            end
            repeat (40) issue_random_request();
            settle();
        end
    endtask

    task automatic test_output_backpressure;
        hold_cycles = 3000;
        repeat (8) issue_request(1'($urandom_range(0, 1)), 28'($urandom_range(0, 4095)), 7'd64);
        settle();
    endtask

    task automatic test_steady_stream;
        quiet = 1'b1;
        repeat (25) issue_random_request();
        settle();
    endtask

    initial
    begin : sink_pacing
        int burst;
        burst = 0;
        forever
        begin
            @(posedge clk);
            if (burst > 0)
                burst--;
            else if (!quiet && $urandom_range(0, 5) == 0)
                burst = $urandom_range(1, 11);
            m_tready <= (burst == 0) && (hold_cycles == 0);
        end
    end

    initial
    begin : sink_hold
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
                hold_cycles--;
        end
    end

    initial
    begin : result_checker
        result_t want;
        result_t got;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got.status        = status_t'(m_tuser[1:0]);
                got.block_created = m_tuser[2];
                got.phys_sector   = m_tdata[31:0];
                got.block_index   = m_tdata[47:32];
                got.block_start   = m_tdata[79:48];
                got.last          = m_tlast;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none, actual %h", $time, got);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("status", 32'(want.status), 32'(got.status));
                    compare_field("phys_sector", want.phys_sector, got.phys_sector);
                    compare_field("block_created", 32'(want.block_created),
                                  32'(got.block_created));
                    compare_field("block_index", 32'(want.block_index), 32'(got.block_index));
                    compare_field("block_start", want.block_start, got.block_start);
                    compare_field("last", 32'(want.last), 32'(got.last));
                end
            end
        end
    end

    initial
    begin
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_translation();
        test_read_only();
        test_geometry_change();
        test_random_traffic();
        test_output_backpressure();
        test_steady_stream();

        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d items missing, expected more, actual none", $time,
                     pending_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
rtl/sdst_pkg.sv
rtl/sdst_ram.sv
rtl/sdst_ctrl.sv
rtl/sparse_disk_sector_translation.sv
tb/tb.sv
